FILE: sv/rvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvr_pkg: shared constants and types for the fixed-axis vector rotator
// Fixed-point widths, the axis scale constant, rounding constants, register
// indexes and the enable bundle of the divide-by-fourteen slice.
// ----------------------------------------------------------------------------
package rvr_pkg;

	// Fixed-point format of all inputs, outputs and registers.
	localparam int unsigned FRAC_BITS = 30;
	localparam int unsigned DATA_W    = 32;

	// Internal widths, each sized to the largest value it can carry.
	localparam int unsigned CROSS_W = 35;  // a x v components and a.v
	localparam int unsigned OMC_W   = 33;  // 1 - cos
	localparam int unsigned AXIS_BITS = 48;
	localparam int unsigned SK_W    = 80;  // sin * K
	localparam int unsigned PROD_W  = 112; // (a x v) * sin * K
	localparam int unsigned TERM1_W = 64;  // v * cos
	localparam int unsigned TERM2_W = PROD_W - AXIS_BITS;
	localparam int unsigned SUM_W   = 66;  // v * cos + cross term
	localparam int unsigned DOT_W   = 67;  // (a.v) * (1 - cos)
	localparam int unsigned AD_W    = 68;  // axis component times the above
	localparam int unsigned ACC_W   = 72;  // full numerator before scaling
	localparam int unsigned QUOT_W  = ACC_W - FRAC_BITS;
	localparam int unsigned Z_W     = 35;  // halved, offset numerator

	// Split points of the partial products.
	localparam int unsigned K_SPLIT   = AXIS_BITS / 2;
	localparam int unsigned SK_PART   = 27;
	localparam int unsigned DOT_SPLIT = 17;
	localparam int unsigned DIV_SPLIT = 18;

	// Configuration register indexes.
	localparam logic CFG_IDX_COS = 1'b0;
	localparam logic CFG_IDX_SIN = 1'b1;

	// Cycles that the derived sine product needs after a register write.
	localparam logic [1:0] CFG_SETTLE = 2'd2;

	// Largest K with 14*K*K <= 2^96, that is floor(2^48 / sqrt(14)).
	function automatic logic [AXIS_BITS-1:0] axis_scale();
		logic [AXIS_BITS-1:0] x;
		logic [AXIS_BITS-1:0] t;
		logic [99:0]          sq;
		x = '0;
		for (int b = AXIS_BITS - 1; b >= 0; b--) begin
			t  = x | (AXIS_BITS'(1) << b);
			sq = 100'(t) * 100'(t) * 100'd14;
			if (sq <= (100'd1 << 96)) begin
				x = t;
			end
		end
		return x;
	endfunction

	localparam logic [AXIS_BITS-1:0] AXIS_K = axis_scale();

	// Unscaled rotation axis (1, 2, 3).
	localparam logic signed [2:0] AXIS_A [3] = '{3'sd1, 3'sd2, 3'sd3};

	localparam logic signed [DATA_W-1:0] COS_RESET  = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [OMC_W-1:0]  ONE_FIX    = OMC_W'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(7) << FRAC_BITS;
	localparam logic signed [QUOT_W-1:0] SAT_BOUND  = QUOT_W'(14) << (DATA_W - 1);

	// floor(z / 7) = floor(z * DIV7_M / 2^DIV7_SHIFT), exact for z < 2^35.
	localparam int unsigned DIV7_SHIFT  = 38;
	localparam logic [63:0] DIV7_M_FULL = ((64'd1 << DIV7_SHIFT) + 64'd6) / 64'd7;
	localparam logic [35:0] DIV7_M      = DIV7_M_FULL[35:0];

	// Load enables of the three stages of the divide slice.
	typedef struct packed {
		logic ld_clamp;
		logic ld_mul;
		logic ld_out;
	} div_en_t;

endpackage
`default_nettype wire

FILE: sv/rvr_div14.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvr_div14: scale, saturate and divide by fourteen
// Takes floor(acc / 2^FRAC_BITS / 14) saturated to 32 bits over three
// registered stages, using a reciprocal multiply split into two products.
// ----------------------------------------------------------------------------
module rvr_div14 (
	input  wire logic                                clk,
	input  wire rvr_pkg::div_en_t                    en,
	input  wire logic signed [rvr_pkg::ACC_W-1:0]    acc,
	output logic signed [rvr_pkg::DATA_W-1:0]        quot
);

	localparam int unsigned QW = rvr_pkg::QUOT_W;
	localparam int unsigned ZW = rvr_pkg::Z_W;
	localparam int unsigned SP = rvr_pkg::DIV_SPLIT;
	localparam int unsigned PW = ZW + 36;

	logic signed [QW-1:0] y;
	logic signed [QW-1:0] y_clamp;
	logic signed [QW-1:0] y_off;
	logic [ZW-1:0]        z_s7;
	logic [ZW-SP+35:0]    pm_hi_s8;
	logic [SP+35:0]       pm_lo_s8;
	logic [PW-1:0]        prod;
	logic [rvr_pkg::DATA_W-1:0] quot_s9;

	assign y = acc[rvr_pkg::ACC_W-1:rvr_pkg::FRAC_BITS];

	// Clamping here makes the quotient land exactly on the saturation limits.
	always_comb begin
		if (y >= rvr_pkg::SAT_BOUND) begin
			y_clamp = rvr_pkg::SAT_BOUND - QW'(1);
		end else if (y < -rvr_pkg::SAT_BOUND) begin
			y_clamp = -rvr_pkg::SAT_BOUND;
		end else begin
			y_clamp = y;
		end
	end

	assign y_off = y_clamp + rvr_pkg::SAT_BOUND;

	always_ff @(posedge clk) begin
		if (en.ld_clamp) begin
			z_s7 <= y_off[ZW:1];
		end
		if (en.ld_mul) begin
			pm_hi_s8 <= z_s7[ZW-1:SP] * rvr_pkg::DIV7_M;
			pm_lo_s8 <= z_s7[SP-1:0] * rvr_pkg::DIV7_M;
		end
		if (en.ld_out) begin
			quot_s9 <= {~prod[rvr_pkg::DIV7_SHIFT+rvr_pkg::DATA_W-1],
				prod[rvr_pkg::DIV7_SHIFT+rvr_pkg::DATA_W-2:rvr_pkg::DIV7_SHIFT]};
		end
	end

	assign prod = (PW'(pm_hi_s8) << SP) + PW'(pm_lo_s8);
	assign quot = $signed(quot_s9);

endmodule
`default_nettype wire

FILE: sv/rodrigues_vector_rotation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rodrigues_vector_rotation: rotation of 3-D directions about a fixed axis
// Streams direction vectors through a nine-stage pipeline that applies
// Rodrigues' formula with software-supplied cosine and sine.
// ----------------------------------------------------------------------------
// Each input transaction carries one direction v = (dir_x, dir_y, dir_z) in
// signed Q2.30 and produces exactly one output transaction with v rotated
// about the unit axis (1,2,3)/sqrt(14): r = v*c + (k x v)*s + k*(k.v)*(1-c),
// rounded to nearest (halves up) and saturated to the signed 32-bit range.
// The block accepts one transaction per clock while the output does not stall
// and no register write is settling; the depth is set by the wide cross-term
// product, which is split into three partial products and summed over the
// following stages, and by the reciprocal divide by fourteen at the end.
// Stalls on the output side back up stage by stage, and empty stages are
// filled while the output waits. The cosine (register 0, reset 1.0) and sine
// (register 1, reset 0.0) are written over the configuration channel, which
// is always ready; after a write the input stays not ready while the product
// of the sine with the axis scale is formed. Registers are to be written only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module rodrigues_vector_rotation (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [rvr_pkg::DATA_W-1:0]  dir_x,
	input  wire logic signed [rvr_pkg::DATA_W-1:0]  dir_y,
	input  wire logic signed [rvr_pkg::DATA_W-1:0]  dir_z,

	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [rvr_pkg::DATA_W-1:0]       rot_x,
	output logic signed [rvr_pkg::DATA_W-1:0]       rot_y,
	output logic signed [rvr_pkg::DATA_W-1:0]       rot_z,

	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic                               cfg_index,
	input  wire logic [rvr_pkg::DATA_W-1:0]         cfg_data
);

	localparam int unsigned DW  = rvr_pkg::DATA_W;
	localparam int unsigned CW  = rvr_pkg::CROSS_W;
	localparam int unsigned OW  = rvr_pkg::OMC_W;
	localparam int unsigned SKW = rvr_pkg::SK_W;
	localparam int unsigned PW  = rvr_pkg::PROD_W;
	localparam int unsigned T1W = rvr_pkg::TERM1_W;
	localparam int unsigned T2W = rvr_pkg::TERM2_W;
	localparam int unsigned SW  = rvr_pkg::SUM_W;
	localparam int unsigned DTW = rvr_pkg::DOT_W;
	localparam int unsigned ADW = rvr_pkg::AD_W;
	localparam int unsigned AW  = rvr_pkg::ACC_W;
	localparam int unsigned KS  = rvr_pkg::K_SPLIT;
	localparam int unsigned SKP = rvr_pkg::SK_PART;
	localparam int unsigned DS  = rvr_pkg::DOT_SPLIT;
	localparam int unsigned AB  = rvr_pkg::AXIS_BITS;

	// ------------------------------------------------------------------
	// Configuration registers and the values derived from them.
	// ------------------------------------------------------------------
	logic signed [DW-1:0]      cos_q;
	logic signed [DW-1:0]      sin_q;
	logic signed [OW-1:0]      omc_q;
	logic signed [DW+KS:0]     sk_lo_q;
	logic signed [DW+AB-KS:0]  sk_hi_q;
	logic signed [SKW-1:0]     sk_q;
	logic [1:0]                busy_q;

	assign cfg_ready = 1'b1;

	// The sine is multiplied by the axis scale K in two halves of K, then
	// summed, so each product stays a modest constant multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q   <= rvr_pkg::COS_RESET;
			sin_q   <= '0;
			omc_q   <= '0;
			sk_lo_q <= '0;
			sk_hi_q <= '0;
			sk_q    <= '0;
			busy_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					rvr_pkg::CFG_IDX_COS: cos_q <= $signed(cfg_data);
					rvr_pkg::CFG_IDX_SIN: sin_q <= $signed(cfg_data);
					default: ;
				endcase
				busy_q <= rvr_pkg::CFG_SETTLE;
			end else if (busy_q != '0) begin
				busy_q <= busy_q - 2'd1;
			end
			omc_q   <= rvr_pkg::ONE_FIX - OW'(cos_q);
			sk_lo_q <= sin_q * $signed({1'b0, rvr_pkg::AXIS_K[KS-1:0]});
			sk_hi_q <= sin_q * $signed({1'b0, rvr_pkg::AXIS_K[AB-1:KS]});
			sk_q    <= (SKW'(sk_hi_q) <<< KS) + SKW'(sk_lo_q);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage loads when it is empty or when the
	// stage after it loads, so bubbles collapse under an output stall.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	assign en_s9 = !vld_s9 || out_ready;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign in_ready  = en_s1 && (busy_q == '0);
	assign out_valid = vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid && (busy_q == '0);
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: cross product u = a x v and dot product d = a.v with the
	// unscaled axis a = (1, 2, 3). Both are exact.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] ex, ey, ez;
	logic signed [CW-1:0] u_in [3];
	logic signed [CW-1:0] d_in;

	assign ex = CW'(dir_x);
	assign ey = CW'(dir_y);
	assign ez = CW'(dir_z);

	assign u_in[0] = (ez <<< 1) - (ey <<< 1) - ey;
	assign u_in[1] = (ex <<< 1) + ex - ez;
	assign u_in[2] = ey - (ex <<< 1);
	assign d_in    = ex + (ey <<< 1) + (ez <<< 1) + ez;

	logic signed [DW-1:0] v_s1 [3];
	logic signed [CW-1:0] u_s1 [3];
	logic signed [CW-1:0] d_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			v_s1[0] <= dir_x;
			v_s1[1] <= dir_y;
			v_s1[2] <= dir_z;
			u_s1    <= u_in;
			d_s1    <= d_in;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 and 3: the shared product d * (1 - c), split on d and
	// reassembled in the next stage.
	// ------------------------------------------------------------------
	logic signed [DS:0]          d_lo;
	logic signed [CW-DS-1:0]     d_hi;
	logic signed [OW+DS:0]       pd_lo_s2;
	logic signed [OW+CW-DS-1:0]  pd_hi_s2;
	logic signed [DTW-1:0]       dd_s3;

	assign d_lo = $signed({1'b0, d_s1[DS-1:0]});
	assign d_hi = d_s1[CW-1:DS];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pd_lo_s2 <= d_lo * omc_q;
			pd_hi_s2 <= d_hi * omc_q;
		end
		if (en_s3) begin
			dd_s3 <= (DTW'(pd_hi_s2) <<< DS) + DTW'(pd_lo_s2);
		end
	end

	// Slices of sin * K for the cross-term partial products.
	logic signed [SKP:0]           sk_lo_w;
	logic signed [SKP:0]           sk_mid_w;
	logic signed [SKW-2*SKP-1:0]   sk_hi_w;

	assign sk_lo_w  = $signed({1'b0, sk_q[SKP-1:0]});
	assign sk_mid_w = $signed({1'b0, sk_q[2*SKP-1:SKP]});
	assign sk_hi_w  = sk_q[SKW-1:2*SKP];

	// ------------------------------------------------------------------
	// Per-component lanes, stages 2 to 6:
	//   s2  v*c and the three partial products of u * s * K
	//   s3  partial products summed
	//   s4  cross term rounded to the 2^60 scale; axis times d*(1-c)
	//   s5  v*c plus cross term
	//   s6  14*(v*c + cross) + a_i*d*(1-c) + rounding half
	// Stages 7 to 9 scale, saturate and divide by fourteen.
	// ------------------------------------------------------------------
	logic signed [DW-1:0] quot [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [T1W-1:0]         t1_s2;
		logic signed [CW+SKP:0]        pu_lo_s2;
		logic signed [CW+SKP:0]        pu_mid_s2;
		logic signed [CW+SKW-2*SKP-1:0] pu_hi_s2;
		logic signed [T1W-1:0]         t1_s3;
		logic signed [PW-1:0]          p_s3;
		logic signed [PW-1:0]          p_rnd;
		logic signed [T1W-1:0]         t1_s4;
		logic signed [T2W-1:0]         t2_s4;
		logic signed [ADW-1:0]         ad_s4;
		logic signed [SW-1:0]          sum_s5;
		logic signed [ADW-1:0]         ad_s5;
		logic signed [AW-1:0]          acc_s6;
		rvr_pkg::div_en_t              div_en;

		assign p_rnd = p_s3 + (PW'(1) <<< (AB - 1));

		always_ff @(posedge clk) begin
			if (en_s2) begin
				t1_s2     <= v_s1[i] * cos_q;
				pu_lo_s2  <= u_s1[i] * sk_lo_w;
				pu_mid_s2 <= u_s1[i] * sk_mid_w;
				pu_hi_s2  <= u_s1[i] * sk_hi_w;
			end
			if (en_s3) begin
				t1_s3 <= t1_s2;
				p_s3  <= (PW'(pu_hi_s2) <<< (2 * SKP)) + (PW'(pu_mid_s2) <<< SKP)
					+ PW'(pu_lo_s2);
			end
			if (en_s4) begin
				t1_s4 <= t1_s3;
				t2_s4 <= p_rnd[PW-1:AB];
				ad_s4 <= ADW'(dd_s3) * ADW'(rvr_pkg::AXIS_A[i]);
			end
			if (en_s5) begin
				sum_s5 <= SW'(t1_s4) + SW'(t2_s4);
				ad_s5  <= ad_s4;
			end
			if (en_s6) begin
				acc_s6 <= (AW'(sum_s5) <<< 4) - (AW'(sum_s5) <<< 1) + AW'(ad_s5)
					+ rvr_pkg::ROUND_HALF;
			end
		end

		assign div_en.ld_clamp = en_s7;
		assign div_en.ld_mul   = en_s8;
		assign div_en.ld_out   = en_s9;

		rvr_div14 u_div (
			.clk  (clk),
			.en   (div_en),
			.acc  (acc_s6),
			.quot (quot[i])
		);
	end

	assign rot_x = quot[0];
	assign rot_y = quot[1];
	assign rot_z = quot[2];

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fixed-axis vector rotator
// Streams direction vectors through the rotator under several cosine and sine
// settings. It predicts every rotated vector with exact wide integer math and
// compares each output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	// Bench timing. Each setting change waits for an empty pipeline plus a
	// margin that covers the nine-stage latency of the block.
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int BLOCK_ITEMS  = 100;
	localparam int RANDOM_BLOCKS = 6;

	// Handy Q2.30 values.
	localparam logic signed [rvr_pkg::DATA_W-1:0] ONE_Q  = 32'sh4000_0000;
	localparam logic signed [rvr_pkg::DATA_W-1:0] MAX_Q  = 32'sh7FFF_FFFF;
	localparam logic signed [rvr_pkg::DATA_W-1:0] MIN_Q  = 32'sh8000_0000;

	typedef struct packed {
		logic signed [rvr_pkg::DATA_W-1:0] x;
		logic signed [rvr_pkg::DATA_W-1:0] y;
		logic signed [rvr_pkg::DATA_W-1:0] z;
	} vec_t;

	// A pending job for the driver: a direction, a register write, or a
	// request that the receiver hold off for a long stretch.
	typedef enum logic [1:0] {
		TX_DIR,
		TX_CFG,
		TX_HOLD
	} tx_kind_e;

	typedef struct packed {
		tx_kind_e                   kind;
		logic                       index;
		logic [rvr_pkg::DATA_W-1:0] data;
		vec_t                       dir;
	} tx_t;

	// Receiver stall patterns, picked at random by the receiver.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_QUARTER,
		RX_MOSTLY
	} rx_pattern_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [rvr_pkg::DATA_W-1:0] dir_x = '0;
	logic signed [rvr_pkg::DATA_W-1:0] dir_y = '0;
	logic signed [rvr_pkg::DATA_W-1:0] dir_z = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [rvr_pkg::DATA_W-1:0] rot_x;
	logic signed [rvr_pkg::DATA_W-1:0] rot_y;
	logic signed [rvr_pkg::DATA_W-1:0] rot_z;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic                              cfg_index = rvr_pkg::CFG_IDX_COS;
	logic [rvr_pkg::DATA_W-1:0]        cfg_data = '0;

	rodrigues_vector_rotation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rot_x    (rot_x),
		.rot_y    (rot_y),
		.rot_z    (rot_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Work still to be driven, and rotated vectors still owed by the block.
	tx_t  pending[$];
	vec_t expected_rot[$];

	// Bench copy of the two angle registers, starting from their reset values.
	logic signed [rvr_pkg::DATA_W-1:0] cos_reg = ONE_Q;
	logic signed [rvr_pkg::DATA_W-1:0] sin_reg = '0;

	// floor(2^48 / sqrt(14)); filled in at time zero.
	logic [63:0] axis_k;

	// Handshake flags sampled at the rising edge and read by the driver.
	logic dir_taken = 1'b0;
	logic reg_taken = 1'b0;

	int mismatches    = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	int quiet_cycles  = 0;
	int burst_left    = 1;
	int gap_left      = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int rx_cycle      = 0;
	rx_pattern_e rx_mode = RX_ALWAYS;
	tx_t nxt;

	initial begin
		forever #2 clk = ~clk;
	end

	// Largest K with K*K <= floor(2^96 / 14), by the digit-by-digit square
	// root. That is the same as the largest K with 14*K*K <= 2^96.
	function automatic logic [63:0] axis_gain();
		logic [127:0] rest;
		logic [127:0] root;
		logic [127:0] bitv;
		rest = (128'd1 << 96) / 128'd14;
		root = '0;
		bitv = 128'd1 << 96;
		while (bitv > rest) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rest >= root + bitv) begin
				rest = rest - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root[63:0];
	endfunction

	// Rotates one direction about (1,2,3)/sqrt(14). All terms are kept on the
	// 2^60 scale in 128-bit signed integers, so nothing is lost until the
	// two rounding steps: the cross term, divided by 2^48, to the nearest integer, and the final
	// sum, divided by 14 * 2^30, to the nearest integer with halves up.
	function automatic vec_t rotate_dir(vec_t v, logic signed [rvr_pkg::DATA_W-1:0] c,
			logic signed [rvr_pkg::DATA_W-1:0] s);
		logic signed [127:0] comp [3];
		logic signed [127:0] cross_p [3];
		logic signed [rvr_pkg::DATA_W-1:0] res [3];
		logic signed [127:0] dot, omc, cw, sw, kw, t1, t2, t3, acc, q;
		vec_t r;
		comp[0] = $signed(v.x);
		comp[1] = $signed(v.y);
		comp[2] = $signed(v.z);
		cw = c;
		sw = s;
		kw = $signed({64'd0, axis_k});
		omc = (128'sd1 <<< rvr_pkg::FRAC_BITS) - cw;
		cross_p[0] = 2 * comp[2] - 3 * comp[1];
		cross_p[1] = 3 * comp[0] - comp[2];
		cross_p[2] = comp[1] - 2 * comp[0];
		dot = comp[0] + 2 * comp[1] + 3 * comp[2];
		for (int i = 0; i < 3; i++) begin
			t1 = comp[i] * cw;
			t2 = (cross_p[i] * sw * kw + (128'sd1 <<< 47)) >>> 48;
			t3 = (i + 1) * dot * omc;
			acc = (14 * (t1 + t2) + t3 + (128'sd7 <<< rvr_pkg::FRAC_BITS))
				>>> rvr_pkg::FRAC_BITS;
			// Signed division truncates; step down once for a negative
			// remainder to get the floor.
			q = acc / 14;
			if (acc % 14 != 0 && acc < 0) q = q - 1;
			if (q > 128'sd2147483647)
				res[i] = MAX_Q;
			else if (q < -128'sd2147483648)
				res[i] = MIN_Q;
			else
				res[i] = q[rvr_pkg::DATA_W-1:0];
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		return r;
	endfunction

	task automatic add_dir(input logic signed [rvr_pkg::DATA_W-1:0] x,
			input logic signed [rvr_pkg::DATA_W-1:0] y,
			input logic signed [rvr_pkg::DATA_W-1:0] z);
		tx_t t;
		t = '0;
		t.kind = TX_DIR;
		t.dir.x = x;
		t.dir.y = y;
		t.dir.z = z;
		pending.push_back(t);
	endtask

	task automatic add_cfg(input logic index, input logic [rvr_pkg::DATA_W-1:0] data);
		tx_t t;
		t = '0;
		t.kind = TX_CFG;
		t.index = index;
		t.data = data;
		pending.push_back(t);
	endtask

	// A unit rotation: cosine and sine of a random angle, in Q2.30.
	task automatic add_angle();
		real ang;
		ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
		add_cfg(rvr_pkg::CFG_IDX_COS, $rtoi($cos(ang) * 1073741824.0));
		add_cfg(rvr_pkg::CFG_IDX_SIN, $rtoi($sin(ang) * 1073741824.0));
	endtask

	// One random component in one of several shapes: any 32-bit value, a
	// value within the unit range, a small value, or a corner value such as a range extreme.
	function automatic logic signed [rvr_pkg::DATA_W-1:0] random_component(int shape);
		logic [rvr_pkg::DATA_W-1:0] val;
		case (shape)
		0: begin
			val = $urandom();
		end
		1: begin
			val = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
		end
		2: begin
			val = $urandom_range(0, 2047) - 1024;
		end
		default: begin
			case ($urandom_range(0, 5))
			0: val = MAX_Q;
			1: val = MIN_Q;
			2: val = ONE_Q;
			3: val = -ONE_Q;
			4: val = '1;
			default: val = $urandom();
			endcase
		end
		endcase
		return $signed(val);
	endfunction

	task automatic check_field(input string name,
			input logic signed [rvr_pkg::DATA_W-1:0] want,
			input logic signed [rvr_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %0s at result %0d: expected %0d (%08h), got %0d (%08h)",
					name, results_seen, want, want, got, got);
		end
	endtask

	// Monitor and predictor. Everything here is sampled at the rising edge;
	// the driver only changes inputs at the falling edge, so nothing races.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results still owed",
					cycle_count, expected_rot.size());
				$display("TEST FAILED");
				$finish;
			end else begin
				dir_taken <= in_valid && in_ready;
				reg_taken <= cfg_valid && cfg_ready;

				// Register writes only happen with nothing in flight, so the
				// bench copy can change right away.
				if (cfg_valid && cfg_ready) begin
					if (cfg_index == rvr_pkg::CFG_IDX_COS)
						cos_reg = cfg_data;
					else
						sin_reg = cfg_data;
				end

				if (in_valid && in_ready)
					expected_rot.push_back(rotate_dir('{dir_x, dir_y, dir_z},
						cos_reg, sin_reg));

				if (out_valid && out_ready) begin
					if (expected_rot.size() == 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("unexpected result %0d: %0d %0d %0d",
								results_seen, rot_x, rot_y, rot_z);
					end else begin
						check_field("rot_x", expected_rot[0].x, rot_x);
						check_field("rot_y", expected_rot[0].y, rot_y);
						check_field("rot_z", expected_rot[0].z, rot_z);
						void'(expected_rot.pop_front());
					end
					results_seen++;
				end
			end
		end
	end

	// Driver. A transaction is retired at the falling edge after the rising
	// edge that accepted it, and the next one is put up at once unless a gap
	// is due. Blocking assignments here are safe since the block only samples
	// at the rising edge, and each signal settles once per falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && dir_taken) in_valid = 1'b0;
			if (cfg_valid && reg_taken) cfg_valid = 1'b0;

			if (expected_rot.size() == 0 && !in_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			if (!in_valid && !cfg_valid && pending.size() != 0) begin
				case (pending[0].kind)
				TX_CFG: begin
					// Settings only change on a drained pipeline.
					if (quiet_cycles >= DRAIN_CYCLES) begin
						nxt = pending.pop_front();
						cfg_index = nxt.index;
						cfg_data = nxt.data;
						cfg_valid = 1'b1;
					end
				end
				TX_HOLD: begin
					void'(pending.pop_front());
					hold_requests++;
				end
				default: begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						nxt = pending.pop_front();
						dir_x = nxt.dir.x;
						dir_y = nxt.dir.y;
						dir_z = nxt.dir.z;
						in_valid = 1'b1;
						// Bursts of random length; gaps are mostly short
						// but sometimes absent or long.
						if (burst_left > 1) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 48);
							case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 2);
							2: gap_left = $urandom_range(0, 6);
							default: gap_left = $urandom_range(10, 30);
							endcase
						end
					end
				end
				endcase
			end
		end
	end

	// Receiver. Its stall pattern is independent of the sender. A hold
	// request from the driver makes it refuse results for a long stretch,
	// counted here, while the sender keeps offering directions.
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 50 == 0) rx_mode = rx_pattern_e'($urandom_range(0, 3));
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				case (rx_mode)
				RX_ALWAYS: out_ready = 1'b1;
				RX_COIN: out_ready = $urandom_range(0, 1);
				RX_QUARTER: out_ready = (rx_cycle % 4 == 0);
				default: out_ready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int shape;
		axis_k = axis_gain();

		// With the reset setting the rotation is the identity, so these show
		// the rounding of the plain term and the range extremes.
		add_dir(0, 0, 0);
		add_dir(MAX_Q, MAX_Q, MAX_Q);
		add_dir(MIN_Q, MIN_Q, MIN_Q);
		add_dir(ONE_Q, 0, 0);
		add_dir(0, ONE_Q, 0);
		add_dir(0, 0, ONE_Q);
		add_dir(MAX_Q, MIN_Q, -1);

		// Quarter turn. A vector along the axis must come back unchanged.
		add_cfg(rvr_pkg::CFG_IDX_COS, 0);
		add_cfg(rvr_pkg::CFG_IDX_SIN, ONE_Q);
		add_dir(ONE_Q, 0, 0);
		add_dir(0, ONE_Q, 0);
		add_dir(0, 0, ONE_Q);
		add_dir(MIN_Q, MAX_Q, MIN_Q);
		add_dir(-1, -1, -1);
		add_dir(32'sd268435456, 32'sd536870912, 32'sd805306368);

		// Half turn.
		add_cfg(rvr_pkg::CFG_IDX_COS, -ONE_Q);
		add_cfg(rvr_pkg::CFG_IDX_SIN, 0);
		add_dir(ONE_Q, 0, 0);
		add_dir(32'sd268435456, 32'sd536870912, 32'sd805306368);

		// Register extremes, far from any real angle, under which some results saturate.
		add_cfg(rvr_pkg::CFG_IDX_COS, MIN_Q);
		add_cfg(rvr_pkg::CFG_IDX_SIN, MAX_Q);
		add_dir(MAX_Q, MIN_Q, MAX_Q);
		add_dir(MIN_Q, MAX_Q, MIN_Q);
		add_dir(ONE_Q, ONE_Q, ONE_Q);
		add_dir(1, 0, 0);
		add_cfg(rvr_pkg::CFG_IDX_COS, MAX_Q);
		add_cfg(rvr_pkg::CFG_IDX_SIN, MIN_Q);
		add_dir(MAX_Q, MAX_Q, MIN_Q);
		add_dir(MIN_Q, MIN_Q, MAX_Q);
		add_dir(-ONE_Q, ONE_Q, 0);

		// Random blocks, each under its own setting. Half use real angles; the
		// other half use raw register values. The second block starts with a long
		// receiver hold so that the pipeline fills and stalls its input.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk)
			1: begin
				add_angle();
				pending.push_back('{kind: TX_HOLD, index: 1'b0, data: '0, dir: '0});
			end
			2: begin
				add_cfg(rvr_pkg::CFG_IDX_COS, $urandom());
			end
			3: begin
				add_cfg(rvr_pkg::CFG_IDX_COS, $urandom());
				add_cfg(rvr_pkg::CFG_IDX_SIN, $urandom());
			end
			4: begin
				add_cfg(rvr_pkg::CFG_IDX_SIN, $urandom());
			end
			default: begin
				add_angle();
			end
			endcase
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				// Unit-range vectors most often, with full-range, small and mixed ones.
				case ($urandom_range(0, 9))
				0, 1, 2: shape = 0;
				3, 4, 5, 6: shape = 1;
				7: shape = 2;
				default: shape = 3;
				endcase
				add_dir(random_component(shape), random_component(shape),
					random_component(shape));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last transaction to be taken and every result to come
		// back, then give the pipeline time to show any stray output.
		while (pending.size() != 0 || in_valid || cfg_valid || expected_rot.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (expected_rot.size() != 0)
			$display("%0d results never arrived", expected_rot.size());
		if (mismatches == 0 && expected_rot.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
